@@ hdl/head_pose_symmetry_score_core_defines.svh @@
// Assertion macros shared by the head pose symmetry score core.
`ifndef HEAD_POSE_SYMMETRY_SCORE_CORE_DEFINES_SVH
`define HEAD_POSE_SYMMETRY_SCORE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define HPSS_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication with a fixed delay in cycles before the consequent.
`define HPSS_ASSERT_DLY(name, ante, dly, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##dly (cons)) \
		else $error(msg);

`endif

@@ hdl/hpss_pkg.sv @@
// Shared types and constants of the head pose symmetry score core.
package hpss_pkg;
	localparam int FIELD_W = 16;
	localparam int RATIO_W = 16;
	localparam int SCORE_W = 16;
	localparam int KNEE_W = 16;
	localparam int RATIO_FRAC_SHIFT = 11;
	localparam int SAT_SHIFT = RATIO_W - RATIO_FRAC_SHIFT;
	localparam int PROD_W = 32;
	localparam int QUO2_W = 17;
	localparam int TERM_W = QUO2_W + 2;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;
	localparam int LATENCY = 4 + RATIO_W + 2 + QUO2_W + 2;

	localparam logic signed [SCORE_W-1:0] SCORE_MAX = 16'sh7FFF;
	localparam logic signed [SCORE_W-1:0] SCORE_MIN = 16'sh8000;

	typedef enum logic [1:0] {
		REG_KNEE_RATIO    = 2'd0,
		REG_KNEE_SCORE    = 2'd1,
		REG_FRONTAL_SCORE = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [KNEE_W-1:0]         knee_ratio;
		logic signed [SCORE_W-1:0] knee_score;
		logic signed [SCORE_W-1:0] frontal_score;
	} cfg_t;

	localparam cfg_t CFG_RST = '{
		knee_ratio:    16'd819,
		knee_score:    16'sd2867,
		frontal_score: 16'sd4096
	};

	typedef struct packed {
		logic sat;
		logic degen;
	} ratio_side_t;

	typedef struct packed {
		logic [RATIO_W-1:0] ratio;
		logic               degen;
		logic               neg;
		logic               big;
	} score_side_t;
endpackage

@@ hdl/hpss_geom.sv @@
// Landmark geometry stages: bisector numerator magnitude and squared eye distance.
module hpss_geom #(
	parameter int CW = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic [hpss_pkg::FIELD_W-1:0] nose_x,
	input  logic [hpss_pkg::FIELD_W-1:0] nose_y,
	input  logic [hpss_pkg::FIELD_W-1:0] left_eye_x,
	input  logic [hpss_pkg::FIELD_W-1:0] left_eye_y,
	input  logic [hpss_pkg::FIELD_W-1:0] right_eye_x,
	input  logic [hpss_pkg::FIELD_W-1:0] right_eye_y,
	output logic                         out_valid,
	output logic [2*CW:0]                rem_init,
	output logic [hpss_pkg::RATIO_W-1:0] num_low,
	output logic [2*CW:0]                den,
	output hpss_pkg::ratio_side_t        side
);
	import hpss_pkg::*;

	localparam int MW = 2 * CW + 2;
	localparam int DW = 2 * CW + 1;
	localparam int NW = 2 * CW + 3;
	localparam int HI_W = MW - SAT_SHIFT;

	logic [CW-1:0] x0, y0, x1, y1, x2, y2;
	logic signed [CW:0] a_c, b_c;
	logic signed [CW+1:0] u_c, v_c;

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic signed [CW:0] a_s1, b_s1;
	logic signed [CW+1:0] u_s1, v_s1;
	logic signed [2*CW+1:0] aa_c, bb_c;
	logic signed [NW-1:0] au_s2, bv_s2;
	logic [2*CW-1:0] aa_s2, bb_s2;
	logic signed [NW-1:0] n2_s3;
	logic [DW-1:0] d_s3;
	logic signed [NW-1:0] n2neg_c;
	logic [MW-1:0] mag_s4;
	logic [DW-1:0] den_s4;
	logic degen_s4;

	assign x0 = nose_x[CW-1:0];
	assign y0 = nose_y[CW-1:0];
	assign x1 = left_eye_x[CW-1:0];
	assign y1 = left_eye_y[CW-1:0];
	assign x2 = right_eye_x[CW-1:0];
	assign y2 = right_eye_y[CW-1:0];

	assign a_c = $signed({1'b0, x1}) - $signed({1'b0, x2});
	assign b_c = $signed({1'b0, y1}) - $signed({1'b0, y2});
	assign u_c = $signed({1'b0, x0, 1'b0}) - $signed({2'b00, x1}) - $signed({2'b00, x2});
	assign v_c = $signed({1'b0, y0, 1'b0}) - $signed({2'b00, y1}) - $signed({2'b00, y2});

	assign aa_c = a_s1 * a_s1;
	assign bb_c = b_s1 * b_s1;
	assign n2neg_c = -n2_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		a_s1 <= a_c;
		b_s1 <= b_c;
		u_s1 <= u_c;
		v_s1 <= v_c;

		au_s2 <= a_s1 * u_s1;
		bv_s2 <= b_s1 * v_s1;
		aa_s2 <= aa_c[2*CW-1:0];
		bb_s2 <= bb_c[2*CW-1:0];

		n2_s3 <= au_s2 + bv_s2;
		d_s3 <= {1'b0, aa_s2} + {1'b0, bb_s2};

		mag_s4 <= n2_s3[NW-1] ? n2neg_c[MW-1:0] : n2_s3[MW-1:0];
		den_s4 <= d_s3;
		degen_s4 <= (d_s3 == '0);
	end

	// The ratio saturates exactly when the magnitude reaches 32 times the divisor.
	assign out_valid = vld_s4;
	assign rem_init = {{(DW - HI_W){1'b0}}, mag_s4[MW-1:SAT_SHIFT]};
	assign num_low = {mag_s4[SAT_SHIFT-1:0], {RATIO_FRAC_SHIFT{1'b0}}};
	assign den = den_s4;

	always_comb begin
		side.sat = (rem_init >= den_s4);
		side.degen = degen_s4;
	end
endmodule

@@ hdl/hpss_udiv.sv @@
// Pipelined restoring divider that retires one quotient bit per stage.
module hpss_udiv #(
	parameter int QW = 16,
	parameter int DW = 33,
	parameter int SW = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [DW-1:0] in_rem,
	input  logic [QW-1:0] in_num,
	input  logic [DW-1:0] in_den,
	input  logic [SW-1:0] in_side,
	output logic          out_valid,
	output logic [QW-1:0] out_quo,
	output logic [DW-1:0] out_rem,
	output logic [SW-1:0] out_side
);
	logic          vld_s  [QW];
	logic [DW-1:0] rem_s  [QW];
	logic [QW-1:0] num_s  [QW];
	logic [QW-1:0] quo_s  [QW];
	logic [DW-1:0] den_s  [QW];
	logic [SW-1:0] side_s [QW];

	logic [DW-1:0] rem_n [QW];
	logic [QW-1:0] num_n [QW];
	logic [QW-1:0] quo_n [QW];

	always_comb begin
		logic [DW-1:0] prem;
		logic [QW-1:0] pnum;
		logic [QW-1:0] pquo;
		logic [DW-1:0] pden;
		logic [DW:0]   trial;
		logic [DW:0]   diff;
		logic          ge;
		for (int k = 0; k < QW; k++) begin
			if (k == 0) begin
				prem = in_rem;
				pnum = in_num;
				pquo = '0;
				pden = in_den;
			end else begin
				prem = rem_s[k-1];
				pnum = num_s[k-1];
				pquo = quo_s[k-1];
				pden = den_s[k-1];
			end
			trial = {prem, pnum[QW-1]};
			diff = trial - {1'b0, pden};
			ge = ~diff[DW];
			rem_n[k] = ge ? diff[DW-1:0] : trial[DW-1:0];
			num_n[k] = {pnum[QW-2:0], 1'b0};
			quo_n[k] = {pquo[QW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < QW; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else begin
			for (int k = 0; k < QW; k++) begin
				if (k == 0) begin
					vld_s[k] <= in_valid;
				end else begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < QW; k++) begin
			rem_s[k] <= rem_n[k];
			num_s[k] <= num_n[k];
			quo_s[k] <= quo_n[k];
			if (k == 0) begin
				den_s[k] <= in_den;
				side_s[k] <= in_side;
			end else begin
				den_s[k] <= den_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign out_valid = vld_s[QW-1];
	assign out_quo = quo_s[QW-1];
	assign out_rem = rem_s[QW-1];
	assign out_side = side_s[QW-1];
endmodule

@@ hdl/hpss_scale.sv @@
// Ratio saturation and signed slope product ahead of the knee division.
module hpss_scale (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic [hpss_pkg::RATIO_W-1:0] in_quo,
	input  hpss_pkg::ratio_side_t        in_side,
	input  hpss_pkg::cfg_t               cfg,
	output logic                         out_valid,
	output logic [hpss_pkg::KNEE_W-1:0]  rem_init,
	output logic [hpss_pkg::QUO2_W-1:0]  num_low,
	output logic [hpss_pkg::KNEE_W-1:0]  den,
	output hpss_pkg::score_side_t        side
);
	import hpss_pkg::*;

	localparam int HI_W = PROD_W - QUO2_W;

	logic [RATIO_W-1:0] ratio_c;
	logic signed [SCORE_W:0] diff_c;
	logic signed [PROD_W:0] pneg_c;

	logic vld_s1, vld_s2;
	logic signed [PROD_W:0] prod_s1;
	logic [RATIO_W-1:0] ratio_s1, ratio_s2;
	logic degen_s1, degen_s2;
	logic [PROD_W-1:0] mag_s2;
	logic neg_s2;

	assign ratio_c = in_side.sat ? {RATIO_W{1'b1}} : in_quo;
	assign diff_c = $signed({cfg.knee_score[SCORE_W-1], cfg.knee_score})
		- $signed({cfg.frontal_score[SCORE_W-1], cfg.frontal_score});
	assign pneg_c = -prod_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= diff_c * $signed({1'b0, ratio_c});
		ratio_s1 <= ratio_c;
		degen_s1 <= in_side.degen;

		neg_s2 <= prod_s1[PROD_W];
		mag_s2 <= prod_s1[PROD_W] ? pneg_c[PROD_W-1:0] : prod_s1[PROD_W-1:0];
		ratio_s2 <= ratio_s1;
		degen_s2 <= degen_s1;
	end

	// A quotient of 2^17 or more pushes the score past either limit.
	assign out_valid = vld_s2;
	assign rem_init = {{(KNEE_W - HI_W){1'b0}}, mag_s2[PROD_W-1:QUO2_W]};
	assign num_low = mag_s2[QUO2_W-1:0];
	assign den = cfg.knee_ratio;

	always_comb begin
		side.ratio = ratio_s2;
		side.degen = degen_s2;
		side.neg = neg_s2;
		side.big = (rem_init >= cfg.knee_ratio);
	end
endmodule

@@ hdl/hpss_sat.sv @@
// Floor rounding, offset by the frontal score, saturation and result registers.
module hpss_sat (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic [hpss_pkg::QUO2_W-1:0]         in_quo,
	input  logic [hpss_pkg::KNEE_W-1:0]         in_rem,
	input  hpss_pkg::score_side_t               in_side,
	input  hpss_pkg::cfg_t                      cfg,
	output logic                                out_valid,
	output logic [hpss_pkg::RATIO_W-1:0]        offset_ratio,
	output logic signed [hpss_pkg::SCORE_W-1:0] pose_score,
	output logic                                degenerate
);
	import hpss_pkg::*;

	logic [QUO2_W:0] tm_c;
	logic signed [TERM_W-1:0] t_c;
	logic signed [TERM_W-1:0] sum_c;
	logic [TERM_W-SCORE_W:0] hi_c;
	logic signed [SCORE_W-1:0] score_c;

	logic vld_s1, vld_s2;
	logic signed [TERM_W-1:0] t_s1;
	logic big_s1, neg_s1, degen_s1;
	logic [RATIO_W-1:0] ratio_s1;
	logic [RATIO_W-1:0] ratio_s2;
	logic signed [SCORE_W-1:0] score_s2;
	logic degen_s2;

	// A negative product with a nonzero remainder rounds one step further down.
	assign tm_c = {1'b0, in_quo} + {{QUO2_W{1'b0}}, (in_side.neg && (in_rem != '0))};
	assign t_c = in_side.neg ? -$signed({1'b0, tm_c}) : $signed({1'b0, tm_c});

	assign sum_c = $signed({{(TERM_W - SCORE_W){cfg.frontal_score[SCORE_W-1]}},
		cfg.frontal_score}) + t_s1;
	assign hi_c = sum_c[TERM_W-1:SCORE_W-1];

	always_comb begin
		if (cfg.knee_ratio == '0) begin
			score_c = cfg.frontal_score;
		end else if (big_s1) begin
			score_c = neg_s1 ? SCORE_MIN : SCORE_MAX;
		end else if ((hi_c == '0) || (hi_c == '1)) begin
			score_c = sum_c[SCORE_W-1:0];
		end else begin
			score_c = sum_c[TERM_W-1] ? SCORE_MIN : SCORE_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		t_s1 <= t_c;
		big_s1 <= in_side.big;
		neg_s1 <= in_side.neg;
		degen_s1 <= in_side.degen;
		ratio_s1 <= in_side.ratio;

		score_s2 <= score_c;
		ratio_s2 <= ratio_s1;
		degen_s2 <= degen_s1;
	end

	assign out_valid = vld_s2;
	assign offset_ratio = ratio_s2;
	assign pose_score = score_s2;
	assign degenerate = degen_s2;
endmodule

@@ hdl/head_pose_symmetry_score_core.sv @@
// An accepted word passes through the geometry, ratio divider, scale, knee divider and saturation stages.
// Throughput: one word per cycle; busy stays low and start is taken every cycle.
// The rate is set by the fully pipelined ratio and knee dividers, one bit per stage.
// Reset clears all valid bits and restores the three mapping registers.
// The receiver cannot stall: done marks each result for exactly one cycle.
`include "head_pose_symmetry_score_core_defines.svh"
module head_pose_symmetry_score_core #(
	parameter int COORD_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	output logic                                done,
	input  logic [hpss_pkg::FIELD_W-1:0]        nose_x,
	input  logic [hpss_pkg::FIELD_W-1:0]        nose_y,
	input  logic [hpss_pkg::FIELD_W-1:0]        left_eye_x,
	input  logic [hpss_pkg::FIELD_W-1:0]        left_eye_y,
	input  logic [hpss_pkg::FIELD_W-1:0]        right_eye_x,
	input  logic [hpss_pkg::FIELD_W-1:0]        right_eye_y,
	output logic [hpss_pkg::RATIO_W-1:0]        offset_ratio,
	output logic signed [hpss_pkg::SCORE_W-1:0] pose_score,
	output logic                                degenerate,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [hpss_pkg::ADDR_W-1:0]         paddr,
	input  logic [hpss_pkg::DATA_W-1:0]         pwdata,
	output logic [hpss_pkg::DATA_W-1:0]         prdata,
	output logic                                pready
);
	import hpss_pkg::*;

	localparam int CW = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
	localparam int DW1 = 2 * CW + 1;

	cfg_t cfg_q;
	reg_idx_t reg_idx;
	logic wr_en;

	logic g_vld;
	logic [DW1-1:0] g_rem, g_den;
	logic [RATIO_W-1:0] g_num;
	ratio_side_t g_side;

	logic d1_vld;
	logic [RATIO_W-1:0] d1_quo;
	ratio_side_t d1_side;

	logic s_vld;
	logic [KNEE_W-1:0] s_rem, s_den;
	logic [QUO2_W-1:0] s_num;
	score_side_t s_side;

	logic d2_vld;
	logic [QUO2_W-1:0] d2_quo;
	logic [KNEE_W-1:0] d2_rem;
	score_side_t d2_side;

	assign busy = 1'b0;
	assign pready = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_KNEE_RATIO: begin
					cfg_q.knee_ratio <= pwdata[KNEE_W-1:0];
				end
				REG_KNEE_SCORE: begin
					cfg_q.knee_score <= $signed(pwdata[SCORE_W-1:0]);
				end
				REG_FRONTAL_SCORE: begin
					cfg_q.frontal_score <= $signed(pwdata[SCORE_W-1:0]);
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_KNEE_RATIO: begin
				prdata = {{(DATA_W - KNEE_W){1'b0}}, cfg_q.knee_ratio};
			end
			REG_KNEE_SCORE: begin
				prdata = {{(DATA_W - SCORE_W){cfg_q.knee_score[SCORE_W-1]}},
					cfg_q.knee_score};
			end
			REG_FRONTAL_SCORE: begin
				prdata = {{(DATA_W - SCORE_W){cfg_q.frontal_score[SCORE_W-1]}},
					cfg_q.frontal_score};
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	hpss_geom #(
		.CW(CW)
	) u_geom (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (start),
		.nose_x      (nose_x),
		.nose_y      (nose_y),
		.left_eye_x  (left_eye_x),
		.left_eye_y  (left_eye_y),
		.right_eye_x (right_eye_x),
		.right_eye_y (right_eye_y),
		.out_valid   (g_vld),
		.rem_init    (g_rem),
		.num_low     (g_num),
		.den         (g_den),
		.side        (g_side)
	);

	hpss_udiv #(
		.QW(RATIO_W),
		.DW(DW1),
		.SW($bits(ratio_side_t))
	) u_div_ratio (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (g_vld),
		.in_rem    (g_rem),
		.in_num    (g_num),
		.in_den    (g_den),
		.in_side   (g_side),
		.out_valid (d1_vld),
		.out_quo   (d1_quo),
		.out_rem   (),
		.out_side  (d1_side)
	);

	hpss_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (d1_vld),
		.in_quo    (d1_quo),
		.in_side   (d1_side),
		.cfg       (cfg_q),
		.out_valid (s_vld),
		.rem_init  (s_rem),
		.num_low   (s_num),
		.den       (s_den),
		.side      (s_side)
	);

	hpss_udiv #(
		.QW(QUO2_W),
		.DW(KNEE_W),
		.SW($bits(score_side_t))
	) u_div_score (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_vld),
		.in_rem    (s_rem),
		.in_num    (s_num),
		.in_den    (s_den),
		.in_side   (s_side),
		.out_valid (d2_vld),
		.out_quo   (d2_quo),
		.out_rem   (d2_rem),
		.out_side  (d2_side)
	);

	hpss_sat u_sat (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (d2_vld),
		.in_quo       (d2_quo),
		.in_rem       (d2_rem),
		.in_side      (d2_side),
		.cfg          (cfg_q),
		.out_valid    (done),
		.offset_ratio (offset_ratio),
		.pose_score   (pose_score),
		.degenerate   (degenerate)
	);

	`HPSS_ASSERT_DLY(a_word_latency, start && !busy, LATENCY, done, "accepted word gave no result")
	`HPSS_ASSERT_IMP(a_result_source, done, $past(start, LATENCY), "result without a word")
	`HPSS_ASSERT_IMP(a_degen_sat, done && degenerate, offset_ratio == '1, "degenerate ratio not saturated")
	`HPSS_ASSERT_IMP(a_flat_knee, done && (cfg_q.knee_ratio == '0), pose_score == cfg_q.frontal_score, "zero knee score mismatch")
endmodule
